// File: rtl/core/upa_pkg.sv
// Shared types and constants for the ultrasonic perimeter alarm.
// No dependencies; used by every module in rtl/core.
package upa_pkg;

  // Default widths of the echo width counter and the cooldown timer.
  localparam int ECHO_W_DEF  = 16;
  localparam int TIMER_W_DEF = 26;

  localparam int POLL_W   = 20;
  localparam int THR_W    = 16;
  localparam int COOL_W   = 26;
  localparam int BEEP_W   = 20;
  localparam int TRIG_W   = 8;
  localparam int DIST_W   = 11;
  localparam int CMD_W    = 8;
  localparam int ALARM_W  = 2;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;
  localparam int REG_IDX_W = 3;

  // Distance in cm is (width * DIST_SCALE) >> DIST_SHIFT, clipped to DIST_LIMIT.
  localparam int DIST_SCALE = 1124;
  localparam int DIST_SHIFT = 16;
  localparam int DIST_LIMIT = 1124;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_POLL   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_THRESH = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COOL   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BEEP   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TRIG   = 3'd4;

  // Register reset values.
  localparam logic [POLL_W-1:0] POLL_RST   = 20'd50000;
  localparam logic [THR_W-1:0]  THRESH_RST = 16'd5830;
  localparam logic [COOL_W-1:0] COOL_RST   = 26'd3000000;
  localparam logic [BEEP_W-1:0] BEEP_RST   = 20'd250000;
  localparam logic [TRIG_W-1:0] TRIG_RST   = 8'd10;

  // Host command bytes.
  localparam logic [CMD_W-1:0] CMD_ARM    = 8'hFF;
  localparam logic [CMD_W-1:0] CMD_DISARM = 8'h00;

  // Alarm report codes.
  localparam logic [ALARM_W-1:0] ALARM_NONE     = 2'd0;
  localparam logic [ALARM_W-1:0] ALARM_ARMED    = 2'd1;
  localparam logic [ALARM_W-1:0] ALARM_DISARMED = 2'd2;

  typedef struct packed {
    logic [POLL_W-1:0] poll_interval_us;
    logic [THR_W-1:0]  threshold_width_us;
    logic [COOL_W-1:0] cooldown_us;
    logic [BEEP_W-1:0] beep_half_us;
    logic [TRIG_W-1:0] trig_width_us;
  } cfg_t;

  // Per-tick results of the poll, cooldown, command and buzzer logic.
  typedef struct packed {
    logic               trig_level;
    logic               buzzer_level;
    logic               report_valid;
    logic               breach;
    logic               breach_event;
    logic [ALARM_W-1:0] alarm_report;
  } ctrl_res_t;

endpackage

// File: rtl/core/upa_regs.sv
// Configuration register file behind an APB-style port.
// Depends on upa_pkg for register indexes, widths and reset values.
module upa_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [upa_pkg::PADDR_W-1:0]   paddr,
  input  logic [upa_pkg::PDATA_W-1:0]   pwdata,
  output logic [upa_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output upa_pkg::cfg_t                 cfg
);

  logic                            wr_en;
  logic [upa_pkg::REG_IDX_W-1:0]   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[upa_pkg::PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poll_interval_us   <= upa_pkg::POLL_RST;
      cfg.threshold_width_us <= upa_pkg::THRESH_RST;
      cfg.cooldown_us        <= upa_pkg::COOL_RST;
      cfg.beep_half_us       <= upa_pkg::BEEP_RST;
      cfg.trig_width_us      <= upa_pkg::TRIG_RST;
    end else if (wr_en) begin
      unique case (idx)
        upa_pkg::REG_POLL:   cfg.poll_interval_us   <= pwdata[upa_pkg::POLL_W-1:0];
        upa_pkg::REG_THRESH: cfg.threshold_width_us <= pwdata[upa_pkg::THR_W-1:0];
        upa_pkg::REG_COOL:   cfg.cooldown_us        <= pwdata[upa_pkg::COOL_W-1:0];
        upa_pkg::REG_BEEP:   cfg.beep_half_us       <= pwdata[upa_pkg::BEEP_W-1:0];
        upa_pkg::REG_TRIG:   cfg.trig_width_us      <= pwdata[upa_pkg::TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      upa_pkg::REG_POLL:   prdata = upa_pkg::PDATA_W'(cfg.poll_interval_us);
      upa_pkg::REG_THRESH: prdata = upa_pkg::PDATA_W'(cfg.threshold_width_us);
      upa_pkg::REG_COOL:   prdata = upa_pkg::PDATA_W'(cfg.cooldown_us);
      upa_pkg::REG_BEEP:   prdata = upa_pkg::PDATA_W'(cfg.beep_half_us);
      upa_pkg::REG_TRIG:   prdata = upa_pkg::PDATA_W'(cfg.trig_width_us);
      default:             prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/upa_echo.sv
// Echo pulse timer and distance conversion.
// Depends on upa_pkg for the distance scale and output width.
module upa_echo #(
  parameter int ECHO_WIDTH_BITS = upa_pkg::ECHO_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  logic                        echo_level,
  output logic [ECHO_WIDTH_BITS-1:0]  last_width_next,
  output logic                        width_known_next,
  output logic [upa_pkg::DIST_W-1:0]  distance_cm
);

  localparam int EW = ECHO_WIDTH_BITS;
  localparam int PW = (EW + upa_pkg::DIST_W > 27) ? EW + upa_pkg::DIST_W : 27;

  logic          echo_prev;
  logic [EW-1:0] echo_counter;
  logic [EW-1:0] echo_counter_next;
  logic [EW-1:0] last_width;
  logic          width_known;
  logic [PW-1:0] product;
  logic [PW-1:0] scaled;

  always_comb begin
    echo_counter_next = echo_counter;
    last_width_next   = last_width;
    width_known_next  = width_known;
    if (echo_level) begin
      if (!echo_prev) begin
        echo_counter_next = EW'(1);
      end else if (!(&echo_counter)) begin
        echo_counter_next = echo_counter + EW'(1);
      end
    end else if (echo_prev) begin
      // Falling edge closes the pulse; the same tick's poll sees it.
      last_width_next  = echo_counter;
      width_known_next = 1'b1;
    end
  end

  assign product = PW'(last_width_next) * PW'(upa_pkg::DIST_SCALE);
  assign scaled  = product >> upa_pkg::DIST_SHIFT;
  assign distance_cm = (scaled > PW'(upa_pkg::DIST_LIMIT)) ?
                       upa_pkg::DIST_W'(upa_pkg::DIST_LIMIT) : scaled[upa_pkg::DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_prev    <= 1'b0;
      echo_counter <= '0;
      last_width   <= '0;
      width_known  <= 1'b0;
    end else if (fire) begin
      echo_prev    <= echo_level;
      echo_counter <= echo_counter_next;
      last_width   <= last_width_next;
      width_known  <= width_known_next;
    end
  end

endmodule

// File: rtl/core/upa_ctrl.sv
// Poll and trigger timing, breach detection with cooldown, host commands
// and the alarm buzzer. Depends on upa_pkg for the config and result types.
module upa_ctrl #(
  parameter int ECHO_WIDTH_BITS  = upa_pkg::ECHO_W_DEF,
  parameter int TIMER_WIDTH_BITS = upa_pkg::TIMER_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  upa_pkg::cfg_t               cfg,
  input  logic [ECHO_WIDTH_BITS-1:0]  last_width,
  input  logic                        width_known,
  input  logic                        cmd_valid,
  input  logic [upa_pkg::CMD_W-1:0]   cmd_byte,
  output upa_pkg::ctrl_res_t          res
);

  localparam int TW = TIMER_WIDTH_BITS;
  localparam int CW = (TW > upa_pkg::COOL_W) ? TW : upa_pkg::COOL_W;
  localparam int EW = ECHO_WIDTH_BITS;
  localparam int BW = (EW > upa_pkg::THR_W) ? EW : upa_pkg::THR_W;
  localparam int PLW = upa_pkg::POLL_W;
  localparam int BPW = upa_pkg::BEEP_W;
  localparam int TRW = upa_pkg::TRIG_W;

  logic [PLW-1:0] poll_elapsed, poll_elapsed_next, pnext;
  logic [TW-1:0]  cooldown_elapsed, cooldown_elapsed_next, cnext;
  logic [TRW-1:0] trig_remaining, trig_remaining_next, trig_loaded;
  logic           alarm_armed, alarm_armed_next;
  logic [BPW-1:0] beep_count, beep_count_next, beep_count_cmd;
  logic           beep_phase, beep_phase_next, beep_phase_cmd;
  logic           poll_fire;
  logic           breach;
  logic           event_ok;
  logic [BPW:0]   beep_inc;

  always_comb begin
    pnext     = (&poll_elapsed) ? poll_elapsed : poll_elapsed + PLW'(1);
    cnext     = (&cooldown_elapsed) ? cooldown_elapsed : cooldown_elapsed + TW'(1);
    poll_fire = (pnext >= cfg.poll_interval_us);
    breach    = poll_fire && width_known && (last_width != '0) &&
                (BW'(last_width) <= BW'(cfg.threshold_width_us));
    event_ok  = breach && (CW'(cnext) >= CW'(cfg.cooldown_us));

    poll_elapsed_next     = poll_fire ? '0 : pnext;
    cooldown_elapsed_next = event_ok ? '0 : cnext;

    // A poll restarts the trigger pulse, even in the middle of one.
    trig_loaded         = poll_fire ? cfg.trig_width_us : trig_remaining;
    trig_remaining_next = (trig_loaded != '0) ? trig_loaded - TRW'(1) : trig_loaded;

    alarm_armed_next = alarm_armed;
    beep_count_cmd   = beep_count;
    beep_phase_cmd   = beep_phase;
    res.alarm_report = upa_pkg::ALARM_NONE;
    if (cmd_valid) begin
      if (cmd_byte == upa_pkg::CMD_ARM) begin
        alarm_armed_next = 1'b1;
        res.alarm_report = upa_pkg::ALARM_ARMED;
      end else if (cmd_byte == upa_pkg::CMD_DISARM) begin
        alarm_armed_next = 1'b0;
        beep_count_cmd   = '0;
        beep_phase_cmd   = 1'b0;
        res.alarm_report = upa_pkg::ALARM_DISARMED;
      end
    end

    beep_inc        = {1'b0, beep_count_cmd} + (BPW+1)'(1);
    beep_count_next = beep_count_cmd;
    beep_phase_next = beep_phase_cmd;
    if (alarm_armed_next) begin
      if (beep_inc >= {1'b0, cfg.beep_half_us}) begin
        beep_count_next = '0;
        beep_phase_next = ~beep_phase_cmd;
      end else begin
        beep_count_next = beep_inc[BPW-1:0];
      end
    end

    res.trig_level   = (trig_loaded != '0);
    res.buzzer_level = alarm_armed_next && !beep_phase_cmd;
    res.report_valid = poll_fire;
    res.breach       = breach;
    res.breach_event = event_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_elapsed     <= '0;
      cooldown_elapsed <= '0;
      trig_remaining   <= '0;
      alarm_armed      <= 1'b0;
      beep_count       <= '0;
      beep_phase       <= 1'b0;
    end else if (fire) begin
      poll_elapsed     <= poll_elapsed_next;
      cooldown_elapsed <= cooldown_elapsed_next;
      trig_remaining   <= trig_remaining_next;
      alarm_armed      <= alarm_armed_next;
      beep_count       <= beep_count_next;
      beep_phase       <= beep_phase_next;
    end
  end

endmodule

// File: rtl/core/ultrasonic_perimeter_alarm.sv
// Ultrasonic perimeter alarm: one tick beat in, one result beat out.
// A tick beat goes into the input register, then its result into the result
// register. Throughput: one beat per cycle unless result_stall holds a waiting
// result; the echo, poll and buzzer state updates in the same cycle the result is
// built. Reset (synchronous, rst high) clears all timers and state and loads the
// register defaults; beats are accepted right after reset.
module ultrasonic_perimeter_alarm #(
  parameter int ECHO_WIDTH_BITS  = upa_pkg::ECHO_W_DEF,
  parameter int TIMER_WIDTH_BITS = upa_pkg::TIMER_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [upa_pkg::PADDR_W-1:0]   paddr,
  input  logic [upa_pkg::PDATA_W-1:0]   pwdata,
  output logic [upa_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          tick_valid,
  output logic                          tick_stall,
  input  logic                          echo_level,
  input  logic                          cmd_valid,
  input  logic [upa_pkg::CMD_W-1:0]     cmd_byte,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          trig_level,
  output logic                          buzzer_level,
  output logic                          report_valid,
  output logic [upa_pkg::DIST_W-1:0]    distance_cm,
  output logic                          distance_known,
  output logic                          breach,
  output logic                          breach_event,
  output logic [upa_pkg::ALARM_W-1:0]   alarm_report
);

  upa_pkg::cfg_t                cfg;
  upa_pkg::ctrl_res_t           ctrl_res;
  logic                         s1_valid;
  logic                         s1_echo;
  logic                         s1_cmd_valid;
  logic [upa_pkg::CMD_W-1:0]    s1_cmd_byte;
  logic                         advance;
  logic                         fire;
  logic [ECHO_WIDTH_BITS-1:0]   last_width_next;
  logic                         width_known_next;
  logic [upa_pkg::DIST_W-1:0]   distance_next;

  // The result register frees up when empty or when its beat is taken.
  assign advance    = !result_valid || !result_stall;
  assign fire       = s1_valid && advance;
  assign tick_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!tick_stall) begin
      s1_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && !tick_stall) begin
      s1_echo      <= echo_level;
      s1_cmd_valid <= cmd_valid;
      s1_cmd_byte  <= cmd_byte;
    end
  end

  upa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  upa_echo #(
    .ECHO_WIDTH_BITS (ECHO_WIDTH_BITS)
  ) u_echo (
    .clk              (clk),
    .rst              (rst),
    .fire             (fire),
    .echo_level       (s1_echo),
    .last_width_next  (last_width_next),
    .width_known_next (width_known_next),
    .distance_cm      (distance_next)
  );

  upa_ctrl #(
    .ECHO_WIDTH_BITS  (ECHO_WIDTH_BITS),
    .TIMER_WIDTH_BITS (TIMER_WIDTH_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .cfg         (cfg),
    .last_width  (last_width_next),
    .width_known (width_known_next),
    .cmd_valid   (s1_cmd_valid),
    .cmd_byte    (s1_cmd_byte),
    .res         (ctrl_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      trig_level     <= ctrl_res.trig_level;
      buzzer_level   <= ctrl_res.buzzer_level;
      report_valid   <= ctrl_res.report_valid;
      distance_cm    <= distance_next;
      distance_known <= width_known_next;
      breach         <= ctrl_res.breach;
      breach_event   <= ctrl_res.breach_event;
      alarm_report   <= ctrl_res.alarm_report;
    end
  end

endmodule
